// File: rtl/core/sprb_pkg.sv
// shared types and codes for the sorted playback reorder buffer
`timescale 1ns / 1ps
`default_nettype none
package sprb_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int CAP_W     = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// register indexes
	localparam logic CFG_CAPACITY      = 1'b0;
	localparam logic CFG_RELEASE_FIRST = 1'b1;

	// operation codes
	localparam logic [1:0] MODE_INSERT    = 2'd0;
	localparam logic [1:0] MODE_FIND_NUM  = 2'd1;
	localparam logic [1:0] MODE_FIND_PEER = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_DUP  = 2'd2;

	// where the result data comes from
	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_FOUND,
		SRC_NEW,
		SRC_OLD
	} src_t;

	typedef struct packed {
		logic [31:0] num;
		logic [31:0] peer;
		logic [7:0]  tag;
		logic [15:0] pref;
		logic [10:0] plen;
		logic [31:0] side;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_POP,
		S_PREP,
		S_SHIFT,
		S_PUT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic       take;
		logic       scan_en;
		logic       shift_start;
		logic       shift_en;
		logic       pop;
		logic       put;
		logic       load_out;
		logic [1:0] status;
		logic       rel;
		src_t       src;
	} cmd_t;

	typedef struct packed {
		logic       scan_done;
		logic       shift_done;
		logic       hit;
		logic       pos_zero;
		logic       full;
		logic       out_busy;
		logic [1:0] mode;
		logic       rel_first;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/core/sprb_ctrl.sv
// controller state machine of the reorder buffer
`timescale 1ns / 1ps
`default_nettype none
module sprb_ctrl import sprb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	src_t   act_q;

	// state register and insert decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q   <= SRC_ZERO;
		end else begin
			state_q <= state_d;
			if (state_q == S_DECIDE) begin
				if (!sts.full)
					act_q <= SRC_ZERO;
				else if (!sts.rel_first && sts.pos_zero)
					act_q <= SRC_NEW;
				else
					act_q <= SRC_OLD;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.mode != MODE_INSERT && sts.mode != MODE_FIND_NUM &&
				    sts.mode != MODE_FIND_PEER)
					state_d = S_FIN;
				else if (sts.scan_done)
					state_d = (sts.mode == MODE_INSERT) ? S_DECIDE : S_FIN;
			end
			S_DECIDE: begin
				if (sts.hit)
					state_d = S_FIN;
				else if (!sts.full)
					state_d = S_PREP;
				else if (!sts.rel_first && sts.pos_zero)
					state_d = S_FIN;
				else
					state_d = S_POP;
			end
			S_POP:   state_d = S_PREP;
			S_PREP:  state_d = S_SHIFT;
			S_SHIFT: begin
				if (sts.shift_done)
					state_d = S_PUT;
			end
			S_PUT:   state_d = S_FIN;
			S_FIN: begin
				if (!sts.out_busy)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		in_ready        = (state_q == S_IDLE);
		cmd             = '0;
		cmd.src         = SRC_ZERO;
		cmd.status      = ST_MISS;
		cmd.take        = (state_q == S_IDLE) && in_valid;
		cmd.scan_en     = (state_q == S_SCAN);
		cmd.pop         = (state_q == S_POP);
		cmd.shift_start = (state_q == S_PREP);
		cmd.shift_en    = (state_q == S_SHIFT);
		cmd.put         = (state_q == S_PUT);
		if (state_q == S_FIN) begin
			cmd.load_out = !sts.out_busy;
			if (sts.mode == MODE_INSERT) begin
				if (sts.hit) begin
					cmd.status = ST_DUP;
				end else begin
					cmd.status = ST_OK;
					cmd.rel    = (act_q != SRC_ZERO);
					cmd.src    = act_q;
				end
			end else if ((sts.mode == MODE_FIND_NUM || sts.mode == MODE_FIND_PEER) &&
			             sts.hit) begin
				cmd.status = ST_OK;
				cmd.src    = SRC_FOUND;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/sprb_dp.sv
// datapath: entry memory, ring pointers, scan and shift counters, result register
`timescale 1ns / 1ps
`default_nettype none
module sprb_dp import sprb_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cmd_t                         cmd,
	output sts_t                              sts,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_idx,
	input  wire logic [CAP_W-1:0]             cfg_wdata,
	input  wire logic [1:0]                   mode,
	input  wire logic [31:0]                  packet_number,
	input  wire logic [31:0]                  peer_number,
	input  wire logic [7:0]                   net_tag,
	input  wire logic [15:0]                  payload_ref,
	input  wire logic [10:0]                  payload_len,
	input  wire logic [31:0]                  side_info,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        status,
	output logic                              released,
	output logic [31:0]                       out_packet_number,
	output logic [31:0]                       out_peer_number,
	output logic [7:0]                        out_net_tag,
	output logic [15:0]                       out_payload_ref,
	output logic [10:0]                       out_payload_len,
	output logic [31:0]                       out_side_info,
	output logic [$clog2(DEPTH+1)-1:0]        occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	logic [CAP_W-1:0] cap_q;
	logic             relf_q;
	logic [1:0]       mode_q;
	entry_t           new_q, e0_q, fnd_q;
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q, idx_q, cidx_q, pos_q, sh_q, wa_q;
	logic             rv_q, wp_q, hit_q, out_valid_q;

	// logical index to physical ring address
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] x);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(x);
		if (s >= (CW+1)'(DEPTH))
			s = s - (CW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	logic          rd_scan, rd_sh, rd_en, we, stop, hitv, scan_done, shift_done;
	logic [AW-1:0] raddr, waddr;
	entry_t        wdata, src_e;
	logic [EW-1:0] capx, ecap;
	logic [CW-1:0] sh_m1;

	// scan compare on the word read last cycle
	always_comb begin
		sh_m1   = sh_q - CW'(1);
		rd_scan = cmd.scan_en && (idx_q < count_q);
		rd_sh   = cmd.shift_en && (sh_q > pos_q);
		rd_en   = rd_scan || rd_sh;
		raddr   = cmd.scan_en ? phys(head_q, idx_q) : phys(head_q, sh_m1);
		if (mode_q == MODE_FIND_PEER) begin
			stop = (rdata_q.peer == new_q.peer) && (rdata_q.tag == new_q.tag);
			hitv = stop;
		end else begin
			stop = (rdata_q.num >= new_q.num);
			hitv = (rdata_q.num == new_q.num);
		end
		scan_done  = cmd.scan_en && ((rv_q && stop) || (!rv_q && (idx_q >= count_q)));
		shift_done = cmd.shift_en && !wp_q && !(sh_q > pos_q);
		we         = cmd.put || (cmd.shift_en && wp_q);
		waddr      = cmd.put ? phys(head_q, pos_q) : phys(head_q, wa_q);
		wdata      = cmd.put ? new_q : rdata_q;
	end

	// effective capacity and full flag
	always_comb begin
		capx = EW'(cap_q);
		if (capx == '0)
			ecap = EW'(1);
		else if (capx > EW'(DEPTH))
			ecap = EW'(DEPTH);
		else
			ecap = capx;
	end

	always_comb begin
		sts.scan_done  = scan_done;
		sts.shift_done = shift_done;
		sts.hit        = hit_q;
		sts.pos_zero   = (pos_q == '0);
		sts.full       = (EW'(count_q) >= ecap);
		sts.out_busy   = out_valid_q && !out_ready;
		sts.mode       = mode_q;
		sts.rel_first  = relf_q;
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (rd_en)
			rdata_q <= mem[raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			relf_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_CAPACITY:      cap_q  <= cfg_wdata;
				CFG_RELEASE_FIRST: relf_q <= cfg_wdata[0];
				default:           ;
			endcase
		end
	end

	// ring pointers, counters and pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			rv_q    <= 1'b0;
			wp_q    <= 1'b0;
			sh_q    <= '0;
			pos_q   <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (cmd.take) begin
				idx_q <= '0;
				rv_q  <= 1'b0;
			end else if (cmd.scan_en) begin
				rv_q <= rd_scan;
				if (rd_scan)
					idx_q <= idx_q + CW'(1);
			end
			if (scan_done) begin
				pos_q <= (rv_q && stop) ? cidx_q : count_q;
				hit_q <= rv_q && stop && hitv;
			end
			if (cmd.pop) begin
				head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
				count_q <= count_q - CW'(1);
				pos_q   <= (pos_q == '0) ? '0 : pos_q - CW'(1);
			end
			if (cmd.shift_start) begin
				sh_q <= count_q;
				wp_q <= 1'b0;
			end else if (cmd.shift_en) begin
				wp_q <= rd_sh;
				if (rd_sh)
					sh_q <= sh_m1;
			end
			if (cmd.put)
				count_q <= count_q + CW'(1);
		end
	end

	// payload registers of the current word
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q   <= mode;
			new_q    <= '{packet_number, peer_number, net_tag, payload_ref,
			              payload_len, side_info};
		end
		if (cmd.scan_en)
			cidx_q <= idx_q;
		if (cmd.scan_en && rv_q && cidx_q == '0)
			e0_q <= rdata_q;
		if (scan_done)
			fnd_q <= rdata_q;
		if (rd_sh)
			wa_q <= sh_q;
	end

	// result data select
	always_comb begin
		case (cmd.src)
			SRC_FOUND: src_e = fnd_q;
			SRC_NEW:   src_e = new_q;
			SRC_OLD:   src_e = e0_q;
			default:   src_e = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status            <= cmd.status;
			released          <= cmd.rel;
			out_packet_number <= src_e.num;
			out_peer_number   <= src_e.peer;
			out_net_tag       <= src_e.tag;
			out_payload_ref   <= src_e.pref;
			out_payload_len   <= src_e.plen;
			out_side_info     <= src_e.side;
			occupancy         <= count_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/core/sorted_playback_reorder_buffer.sv
// top level of the sorted playback reorder buffer
// Holds up to DEPTH packet descriptors in one memory used as a ring, kept in
// ascending packet-number order. Each word does one operation: insert (with
// duplicate rejection and eviction of the oldest entry once the configured
// capacity is reached), lookup by packet number, or lookup by peer number and
// tag, and returns exactly one result word. Words are handled one at a time:
// a lookup scans the held entries from the oldest; an insert scans up to its
// slot, first pops the oldest entry when it evicts, then shifts the entries
// above the slot and writes the new one, while a rejected duplicate or a new
// word that is itself the oldest ends after the scan. The entry memory has a
// single read port: the search stops at the slot of the new entry and the
// shift walks only the entries above it, so together they visit the held
// entries once. The result sits in an output register, so the next word is
// taken while a result still waits; a word only stalls at its end while the
// previous result is unread. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module sorted_playback_reorder_buffer import sprb_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_idx,
	input  wire logic [CAP_W-1:0]      cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            mode,
	input  wire logic [31:0]           packet_number,
	input  wire logic [31:0]           peer_number,
	input  wire logic [7:0]            net_tag,
	input  wire logic [15:0]           payload_ref,
	input  wire logic [10:0]           payload_len,
	input  wire logic [31:0]           side_info,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 status,
	output logic                       released,
	output logic [31:0]                out_packet_number,
	output logic [31:0]                out_peer_number,
	output logic [7:0]                 out_net_tag,
	output logic [15:0]                out_payload_ref,
	output logic [10:0]                out_payload_len,
	output logic [31:0]                out_side_info,
	output logic [$clog2(DEPTH+1)-1:0] occupancy
);

	cmd_t cmd;
	sts_t sts;

	// sequencing
	sprb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and result path
	sprb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_wdata         (cfg_wdata),
		.mode              (mode),
		.packet_number     (packet_number),
		.peer_number       (peer_number),
		.net_tag           (net_tag),
		.payload_ref       (payload_ref),
		.payload_len       (payload_len),
		.side_info         (side_info),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.released          (released),
		.out_packet_number (out_packet_number),
		.out_peer_number   (out_peer_number),
		.out_net_tag       (out_net_tag),
		.out_payload_ref   (out_payload_ref),
		.out_payload_len   (out_payload_len),
		.out_side_info     (out_side_info),
		.occupancy         (occupancy)
	);

endmodule
`default_nettype wire
